>>> rtl/binhex4_stream_decoder_unit_macros.svh
// Assertion macros shared by the BinHex 4.0 decoder modules.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef BINHEX4_STREAM_DECODER_UNIT_MACROS_SVH
`define BINHEX4_STREAM_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BH4_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bh4 assertion failed");
`define BH4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bh4 assertion failed");
`else
`define BH4_ASSERT_SAME(label, ante, cons)
`define BH4_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/bh4_pkg.sv
// Shared types, constants and functions of the BinHex 4.0 stream decoder.
// No dependencies.
package bh4_pkg;

    localparam logic [7:0] ESCAPE_BYTE = 8'h90;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam int CODE_COUNT = 64;
    localparam logic [CODE_COUNT*8-1:0] CODE_CHARS =
        {"!\"#$%&'()*+,-012345689@ABCDEFGHIJKLMNPQRSTUVXYZ[", 8'h60, "abcdefhijklmpqr"};

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] character;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [7:0]  run_length;
        logic [15:0] check_value;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic step;
        logic feed;
        logic aug_first;
        logic aug_second;
    } cmd_t;

    typedef struct packed {
        logic has_result;
        logic result_ok;
        logic count_last;
    } stat_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input logic [7:0] v_in);
        logic [15:0] c;
        logic [7:0]  v;
        logic        carry;
        c = c_in;
        v = v_in;
        for (int i = 0; i < 8; i++)
        begin
            carry = c[15];
            c = {c[14:0], v[7]};
            if (carry)
            begin
                c = c ^ CRC_POLY;
            end
            v = {v[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [6:0] code_lookup(input logic [7:0] ch);
        logic [6:0] res;
        res = 7'd0;
        for (int i = 0; i < CODE_COUNT; i++)
        begin
            if (CODE_CHARS[(CODE_COUNT-1-i)*8 +: 8] == ch)
            begin
                res = {1'b1, 6'(i)};
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/bh4_stream_if.sv
// Valid/ready channel interfaces for the decoder's character input and result output.
// Depends on bh4_pkg for the payload types.
interface bh4_in_if;
    logic             valid;
    logic             ready;
    bh4_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bh4_out_if;
    logic              valid;
    logic              ready;
    bh4_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/bh4_datapath.sv
// Datapath of the decoder: character mapping, bit packing, escape handling, CRC and result register.
// Depends on bh4_pkg; driven by bh4_ctrl through command and status structs.
module bh4_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  bh4_pkg::in_item_t  item,
    input  bh4_pkg::cmd_t      cmd,
    output bh4_pkg::stat_t     stat,
    output bh4_pkg::out_item_t result
);

    localparam logic [1:0] ACT_CHAR  = 2'd0;
    localparam logic [1:0] ACT_FLUSH = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] MODE_EMPTY     = 2'd0;
    localparam logic [1:0] MODE_HELD      = 2'd1;
    localparam logic [1:0] MODE_HELD_ESC  = 2'd2;
    localparam logic [1:0] MODE_START_ESC = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_START = 2'd1;
    localparam logic [1:0] STAT_END_ESC  = 2'd2;

    logic [13:0] buf_reg, buf_next;
    logic [3:0]  bits_reg, bits_next;
    logic [7:0]  held_reg, held_next;
    logic [1:0]  mode_reg, mode_next;
    logic        stopped_reg, stopped_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] aug_reg, aug_next;
    logic [7:0]  remain_reg, remain_next;
    bh4_pkg::out_item_t out_reg, out_next;

    logic [6:0]  code;
    logic [19:0] joined;
    logic [13:0] packed_bits;
    logic [3:0]  sum_bits;
    logic [3:0]  left_bits;
    logic [7:0]  new_byte;
    logic        res_valid;
    logic [7:0]  res_byte;
    logic [7:0]  res_len;
    logic [1:0]  res_status;

    always_comb
    begin
        code        = bh4_pkg::code_lookup(item.character);
        joined      = {buf_reg, code[5:0]};
        packed_bits = joined[13:0];
        sum_bits    = bits_reg + 4'd6;
        left_bits   = sum_bits - 4'd8;
        new_byte    = 8'(packed_bits >> left_bits);

        buf_next     = buf_reg;
        bits_next    = bits_reg;
        held_next    = held_reg;
        mode_next    = mode_reg;
        stopped_next = stopped_reg;
        res_valid    = 1'b0;
        res_byte     = 8'd0;
        res_len      = 8'd1;
        res_status   = STAT_OK;

        if (item.action == ACT_FLUSH && !stopped_reg)
        begin
            buf_next  = 14'd0;
            bits_next = 4'd0;
            held_next = 8'd0;
            mode_next = MODE_EMPTY;
            if (mode_reg == MODE_HELD)
            begin
                res_valid = 1'b1;
                res_byte  = held_reg;
            end
            else if (mode_reg == MODE_HELD_ESC || mode_reg == MODE_START_ESC)
            begin
                res_valid  = 1'b1;
                res_status = STAT_END_ESC;
            end
        end
        else if (item.action == ACT_CHAR && !stopped_reg && code[6])
        begin
            buf_next = packed_bits;
            if (sum_bits < 4'd8)
            begin
                bits_next = sum_bits;
            end
            else
            begin
                bits_next = left_bits;
                buf_next  = packed_bits & ((14'd1 << left_bits) - 14'd1);
                unique case (mode_reg)
                    MODE_EMPTY:
                    begin
                        if (new_byte == bh4_pkg::ESCAPE_BYTE)
                        begin
                            mode_next = MODE_START_ESC;
                        end
                        else
                        begin
                            held_next = new_byte;
                            mode_next = MODE_HELD;
                        end
                    end
                    MODE_START_ESC:
                    begin
                        if (new_byte == 8'd0)
                        begin
                            held_next = bh4_pkg::ESCAPE_BYTE;
                            mode_next = MODE_HELD;
                        end
                        else
                        begin
                            stopped_next = 1'b1;
                            held_next    = 8'd0;
                            mode_next    = MODE_EMPTY;
                            res_valid    = 1'b1;
                            res_status   = STAT_BAD_START;
                        end
                    end
                    MODE_HELD:
                    begin
                        if (new_byte == bh4_pkg::ESCAPE_BYTE)
                        begin
                            mode_next = MODE_HELD_ESC;
                        end
                        else
                        begin
                            held_next = new_byte;
                            res_valid = 1'b1;
                            res_byte  = held_reg;
                        end
                    end
                    default:
                    begin
                        res_valid = 1'b1;
                        res_byte  = held_reg;
                        if (new_byte == 8'd0)
                        begin
                            held_next = bh4_pkg::ESCAPE_BYTE;
                            mode_next = MODE_HELD;
                        end
                        else
                        begin
                            held_next = 8'd0;
                            mode_next = MODE_EMPTY;
                            res_len   = new_byte;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        crc_next    = crc_reg;
        aug_next    = aug_reg;
        remain_next = remain_reg;
        out_next    = out_reg;
        if (cmd.step)
        begin
            if (item.action == ACT_CLEAR)
            begin
                crc_next = 16'd0;
                aug_next = 16'd0;
            end
            if (res_valid)
            begin
                out_next.data_byte   = res_byte;
                out_next.run_length  = res_len;
                out_next.check_value = aug_reg;
                out_next.status      = res_status;
                remain_next          = res_len;
            end
        end
        if (cmd.feed)
        begin
            crc_next    = bh4_pkg::crc_feed(crc_reg, out_reg.data_byte);
            remain_next = remain_reg - 8'd1;
        end
        if (cmd.aug_first)
        begin
            aug_next = bh4_pkg::crc_feed(crc_reg, 8'd0);
        end
        if (cmd.aug_second)
        begin
            aug_next = bh4_pkg::crc_feed(aug_reg, 8'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg     <= 14'd0;
            bits_reg    <= 4'd0;
            held_reg    <= 8'd0;
            mode_reg    <= MODE_EMPTY;
            stopped_reg <= 1'b0;
            crc_reg     <= 16'd0;
            aug_reg     <= 16'd0;
            remain_reg  <= 8'd0;
        end
        else
        begin
            if (cmd.step)
            begin
                buf_reg     <= buf_next;
                bits_reg    <= bits_next;
                held_reg    <= held_next;
                mode_reg    <= mode_next;
                stopped_reg <= stopped_next;
            end
            crc_reg    <= crc_next;
            aug_reg    <= aug_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign stat.has_result = res_valid;
    assign stat.result_ok  = res_valid && (res_status == STAT_OK);
    assign stat.count_last = (remain_reg == 8'd1);
    assign result          = out_reg;

endmodule

>>> rtl/bh4_ctrl.sv
// Controller of the decoder: input and output handshakes and the CRC sequencing.
// Depends on bh4_pkg and the assertion macro header.
`include "binhex4_stream_decoder_unit_macros.svh"

module bh4_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  bh4_pkg::stat_t stat,
    output bh4_pkg::cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FEED = 2'd1;
    localparam logic [1:0] ST_AUG1 = 2'd2;
    localparam logic [1:0] ST_AUG2 = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.step = 1'b1;
                    if (stat.has_result)
                    begin
                        out_valid_next = 1'b1;
                    end
                    if (stat.result_ok)
                    begin
                        state_next = ST_FEED;
                    end
                end
            end
            ST_FEED:
            begin
                cmd.feed = 1'b1;
                if (stat.count_last)
                begin
                    state_next = ST_AUG1;
                end
            end
            ST_AUG1:
            begin
                cmd.aug_first = 1'b1;
                state_next    = ST_AUG2;
            end
            default:
            begin
                cmd.aug_second = 1'b1;
                state_next     = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `BH4_ASSERT_NEXT(a_ok_result_feeds, cmd.step && stat.result_ok, state_reg == ST_FEED)
    `BH4_ASSERT_NEXT(a_result_shown, cmd.step && stat.has_result, out_valid_reg)
    `BH4_ASSERT_NEXT(a_aug_order, state_reg == ST_AUG1, state_reg == ST_AUG2)
    `BH4_ASSERT_SAME(a_busy_no_accept, state_reg != ST_IDLE, !in_ready)

endmodule

>>> rtl/binhex4_stream_decoder_unit.sv
// BinHex 4.0 stream decoder. One character is taken per transaction; a character or flush that
// completes no result, or that gives an error result, leaves the controller in idle, while one
// that gives a result with status ok is followed by the CRC unit, which counts one byte of the
// run per cycle and then feeds sixteen zero bits in two steps to form the next check value.
// A finished result waits in the output register, and no further character is accepted
// until the receiver has taken it.
// Top level; depends on bh4_pkg, the channel interfaces, bh4_ctrl and bh4_datapath.
module binhex4_stream_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    bh4_in_if.sink      chars,
    bh4_out_if.source   results
);

    bh4_pkg::cmd_t  cmd;
    bh4_pkg::stat_t stat;

    bh4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chars.valid),
        .in_ready  (chars.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bh4_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (chars.payload),
        .cmd    (cmd),
        .stat   (stat),
        .result (results.payload)
    );

endmodule

>>> dv/binhex4_stream_decoder_unit_tb.sv
// Testbench for binhex4_stream_decoder_unit. It drives BinHex character streams with random
// gaps and stalls, and checks every decoded run against a scoreboard that decodes the same input.
// Depends on bh4_pkg and on the bh4_in_if and bh4_out_if channel interfaces.
module binhex4_stream_decoder_unit_tb;

    localparam logic [1:0] ACT_CHAR  = 2'd0;
    localparam logic [1:0] ACT_FLUSH = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_START = 2'd1;
    localparam logic [1:0] ST_CUT_ESC   = 2'd2;

    localparam int GROUP_COUNT  = 64;
    localparam logic [GROUP_COUNT*8-1:0] GROUP_TABLE =
        {"!\"#$%&'()*+,-012345689@ABCDEFGHIJKLMNPQRSTUVXYZ[", 8'h60, "abcdefhijklmpqr"};

    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_AT       = 300;
    localparam int PAUSE_AT      = 600;
    localparam int CALM_AT       = 830;
    localparam int RANDOM_END    = 900;
    localparam int GARBLE_ITEMS  = 50;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [1:0] {HOLD_NONE, HOLD_BYTE, HOLD_BYTE_ESC, HOLD_ESC} hold_t;

    class bh4_scoreboard;
        bh4_pkg::out_item_t runs_due[$];
        int          failures;
        logic [13:0] group_bits;
        logic [3:0]  group_count;
        logic [7:0]  kept_byte;
        hold_t       mode;
        logic [15:0] crc;
        bit          halted;

        function new();
            failures = 0;
            group_bits = '0;
            group_count = '0;
            kept_byte = '0;
            mode = HOLD_NONE;
            crc = '0;
            halted = 1'b0;
        endfunction

        function logic [7:0] char_of(int idx);
            return GROUP_TABLE[(GROUP_COUNT - 1 - idx) * 8 +: 8];
        endfunction

        function logic [6:0] group_of(logic [7:0] ch);
            for (int i = 0; i < GROUP_COUNT; i++)
            begin
                if (char_of(i) == ch)
                    return {1'b1, 6'(i)};
            end
            return 7'd0;
        endfunction

        function logic [15:0] crc_shift(logic [15:0] c, logic [7:0] v);
            logic [15:0] r;
            logic        top;
            r = c;
            for (int i = 7; i >= 0; i--)
            begin
                top = r[15];
                r = {r[14:0], v[i]};
                if (top)
                    r = r ^ bh4_pkg::CRC_POLY;
            end
            return r;
        endfunction

        function void emit_run(logic [7:0] b, logic [7:0] len, logic [1:0] st);
            bh4_pkg::out_item_t r;
            r.data_byte = b;
            r.run_length = len;
            r.check_value = crc_shift(crc_shift(crc, 8'h00), 8'h00);
            r.status = st;
            if (st == ST_OK)
            begin
                for (int i = 0; i < len; i++)
                    crc = crc_shift(crc, b);
            end
            runs_due.push_back(r);
        endfunction

        function void absorb_byte(logic [7:0] b);
            case (mode)
                HOLD_NONE:
                begin
                    if (b == bh4_pkg::ESCAPE_BYTE)
                        mode = HOLD_ESC;
                    else
                    begin
                        kept_byte = b;
                        mode = HOLD_BYTE;
                    end
                end
                HOLD_ESC:
                begin
                    if (b == 8'h00)
                    begin
                        kept_byte = bh4_pkg::ESCAPE_BYTE;
                        mode = HOLD_BYTE;
                    end
                    else
                    begin
                        halted = 1'b1;
                        kept_byte = 8'h00;
                        mode = HOLD_NONE;
                        emit_run(8'h00, 8'd1, ST_BAD_START);
                    end
                end
                HOLD_BYTE:
                begin
                    if (b == bh4_pkg::ESCAPE_BYTE)
                        mode = HOLD_BYTE_ESC;
                    else
                    begin
                        emit_run(kept_byte, 8'd1, ST_OK);
                        kept_byte = b;
                    end
                end
                default:
                begin
                    if (b == 8'h00)
                    begin
                        emit_run(kept_byte, 8'd1, ST_OK);
                        kept_byte = bh4_pkg::ESCAPE_BYTE;
                        mode = HOLD_BYTE;
                    end
                    else
                    begin
                        emit_run(kept_byte, b, ST_OK);
                        kept_byte = 8'h00;
                        mode = HOLD_NONE;
                    end
                end
            endcase
        endfunction

        function void note_char(bh4_pkg::in_item_t it);
            logic [6:0] g;
            logic [7:0] b;
            if (it.action == ACT_CLEAR)
            begin
                crc = '0;
                return;
            end
            if (it.action == ACT_SPARE || halted)
                return;
            if (it.action == ACT_FLUSH)
            begin
                group_bits = '0;
                group_count = '0;
                if (mode == HOLD_BYTE)
                    emit_run(kept_byte, 8'd1, ST_OK);
                else if (mode != HOLD_NONE)
                    emit_run(8'h00, 8'd1, ST_CUT_ESC);
                kept_byte = 8'h00;
                mode = HOLD_NONE;
                return;
            end
            g = group_of(it.character);
            if (!g[6])
                return;
            group_bits = {group_bits[7:0], g[5:0]};
            group_count = group_count + 4'd6;
            if (group_count < 4'd8)
                return;
            group_count = group_count - 4'd8;
            b = 8'(group_bits >> group_count);
            group_bits = group_bits & ((14'd1 << group_count) - 14'd1);
            absorb_byte(b);
        endfunction

        function void check_run(bh4_pkg::out_item_t got);
            bh4_pkg::out_item_t want;
            if (runs_due.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: byte %h run %0d check %h status %0d",
                             got.data_byte, got.run_length, got.check_value, got.status);
                return;
            end
            want = runs_due.pop_front();
            if (got.data_byte !== want.data_byte || got.run_length !== want.run_length ||
                got.check_value !== want.check_value || got.status !== want.status)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("result differs: expected byte %h run %0d check %h status %0d, %s",
                             want.data_byte, want.run_length, want.check_value, want.status,
                             $sformatf("got byte %h run %0d check %h status %0d",
                                       got.data_byte, got.run_length, got.check_value,
                                       got.status));
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bh4_in_if  chars_if ();
    bh4_out_if results_if ();

    binhex4_stream_decoder_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    bh4_scoreboard board;
    logic [7:0]    byte_plan[$];
    bit            drop_tail = 1'b0;
    bit            idle_on = 1'b1;
    bit            long_hold_req = 1'b0;
    int            noise_pct = 0;
    int            items_sent = 0;
    int            quiet_cycles = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (results_if.valid && results_if.ready)
                board.check_run(results_if.payload);
            if (chars_if.valid && chars_if.ready)
                board.note_char(chars_if.payload);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((chars_if.valid && chars_if.ready) || (results_if.valid && results_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("binhex4_stream_decoder_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        results_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                results_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                results_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                results_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_item(logic [1:0] act, logic [7:0] ch);
        bh4_pkg::in_item_t it;
        it.action = act;
        it.character = ch;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.payload <= it;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        chars_if.valid <= 1'b0;
        @(posedge clk);
        while (board.runs_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] skipped_char();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = 8'h20;
            1: c = 8'h0A;
            2: c = 8'h3A;
            default:
            begin
                c = 8'($urandom_range(0, 255));
                while (board.group_of(c) != 7'd0)
                    c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    task automatic send_noise();
        case ($urandom_range(0, 5))
            0: send_item(ACT_SPARE, 8'($urandom_range(0, 255)));
            1: send_item(ACT_CLEAR, 8'($urandom_range(0, 255)));
            default: send_item(ACT_CHAR, skipped_char());
        endcase
    endtask

    task automatic send_group(logic [5:0] g, bit skip);
        if ($urandom_range(0, 99) < noise_pct)
            send_noise();
        if (!skip)
            send_item(ACT_CHAR, board.char_of(g));
    endtask

    task automatic send_bytes();
        logic [15:0] acc;
        logic [5:0]  g;
        int          n;
        int          total;
        int          sent;
        acc = '0;
        n = 0;
        sent = 0;
        total = (8 * byte_plan.size() + 5) / 6;
        foreach (byte_plan[i])
        begin
            acc = {acc[7:0], byte_plan[i]};
            n += 8;
            while (n >= 6)
            begin
                n -= 6;
                g = 6'(acc >> n);
                send_group(g, drop_tail && (sent == total - 1));
                sent++;
            end
        end
        if (n > 0)
        begin
            g = 6'(acc << (6 - n)) | 6'($urandom_range(0, (1 << (6 - n)) - 1));
            send_group(g, drop_tail);
        end
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0: v = 8'h00;
            1: v = 8'hFF;
            default: v = 8'($urandom_range(0, 255));
        endcase
        if (v == bh4_pkg::ESCAPE_BYTE)
            v = 8'h91;
        return v;
    endfunction

    function automatic logic [7:0] run_count();
        if ($urandom_range(0, 19) == 0)
            return 8'($urandom_range(1, 255));
        return 8'($urandom_range(1, 6));
    endfunction

    task automatic send_segment();
        bit holding;
        int tokens;
        holding = 1'b0;
        tokens = $urandom_range(0, 12);
        byte_plan.delete();
        for (int t = 0; t < tokens; t++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    byte_plan.push_back(bh4_pkg::ESCAPE_BYTE);
                    byte_plan.push_back(8'h00);
                    holding = 1'b1;
                end
                1, 2, 3:
                begin
                    if (holding)
                    begin
                        byte_plan.push_back(bh4_pkg::ESCAPE_BYTE);
                        byte_plan.push_back(run_count());
                        holding = 1'b0;
                    end
                    else
                    begin
                        byte_plan.push_back(plain_byte());
                        holding = 1'b1;
                    end
                end
                default:
                begin
                    byte_plan.push_back(plain_byte());
                    holding = 1'b1;
                end
            endcase
        end
        drop_tail = 1'b0;
        case ($urandom_range(0, 9))
            0: byte_plan.push_back(bh4_pkg::ESCAPE_BYTE);
            1: drop_tail = (byte_plan.size() != 0);
            default: ;
        endcase
        send_bytes();
        send_item(ACT_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        bit long_hold_done;
        bit pause_done;
        board = new();
        long_hold_done = 1'b0;
        pause_done = 1'b0;
        rst_n <= 1'b0;
        chars_if.valid <= 1'b0;
        chars_if.payload <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(ACT_CHAR, 8'h00);
        send_item(ACT_SPARE, 8'hFF);
        send_item(ACT_CLEAR, 8'h00);
        byte_plan = '{8'h00, 8'hFF, bh4_pkg::ESCAPE_BYTE, 8'h00, bh4_pkg::ESCAPE_BYTE, 8'hFF};
        send_bytes();
        send_item(ACT_FLUSH, 8'hFF);
        byte_plan = '{bh4_pkg::ESCAPE_BYTE, 8'h00, 8'h41, bh4_pkg::ESCAPE_BYTE, 8'h01, 8'h7E};
        send_bytes();
        send_item(ACT_FLUSH, 8'h00);
        byte_plan = '{bh4_pkg::ESCAPE_BYTE};
        send_bytes();
        send_item(ACT_FLUSH, 8'h00);
        byte_plan = '{8'h33, bh4_pkg::ESCAPE_BYTE};
        send_bytes();
        send_item(ACT_FLUSH, 8'h00);

        noise_pct = 8;
        while (items_sent < RANDOM_END)
        begin
            if (!long_hold_done && items_sent >= HOLD_AT)
            begin
                long_hold_req = 1'b1;
                long_hold_done = 1'b1;
            end
            if (!pause_done && items_sent >= PAUSE_AT)
            begin
                hold_until_drained();
                pause_done = 1'b1;
            end
            if (items_sent >= CALM_AT)
                idle_on = 1'b0;
            send_segment();
        end

        // Unstructured characters may halt decoding, so they come only at the end.
        noise_pct = 0;
        repeat (GARBLE_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 1) == 0)
                send_item(ACT_CHAR, board.char_of($urandom_range(0, GROUP_COUNT - 1)));
            else
                send_item(ACT_CHAR, 8'($urandom_range(0, 255)));
        end

        send_item(ACT_FLUSH, 8'h00);
        drop_tail = 1'b0;
        byte_plan = '{bh4_pkg::ESCAPE_BYTE, 8'h05};
        send_bytes();
        byte_plan = '{8'h12, 8'h34, 8'h56};
        send_bytes();
        send_item(ACT_FLUSH, 8'h00);
        send_item(ACT_CLEAR, 8'h00);
        send_item(ACT_FLUSH, 8'h00);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.runs_due.size() == 0)
            $display("binhex4_stream_decoder_unit: match");
        else
            $display("binhex4_stream_decoder_unit: mismatch");
        $finish;
    end

endmodule
